// ===== hw/rtl/underwater_pixel_attenuation_macros.svh =====
// ----------------------------------------------------------------------------
// Underwater pixel attenuation assertion macros
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef UNDERWATER_PIXEL_ATTENUATION_MACROS_SVH
`define UNDERWATER_PIXEL_ATTENUATION_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define UPA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication
`define UPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define UPA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/upa_pkg.sv =====
// ----------------------------------------------------------------------------
// Underwater pixel attenuation package
// Widths, fixed-point constants, exp table, register map and queue item type.
// ----------------------------------------------------------------------------
package upa_pkg;

   // Channel and field widths
   localparam int NUM_CHAN = 3;
   localparam int PIX_W    = 8;
   localparam int DEPTH_W  = 24;
   localparam int FACTOR_W = 16;
   localparam int ATTEN_W  = 16;

   // Range product and its split for the attenuation multiply
   localparam int RANGE_W     = DEPTH_W + FACTOR_W;
   localparam int RANGE_SPLIT = 24;
   localparam int HI_W        = RANGE_W - RANGE_SPLIT;
   localparam int HI_PROD_W   = HI_W + ATTEN_W;
   localparam int LO_PROD_W   = RANGE_SPLIT + ATTEN_W;
   localparam int LO_TOP_W    = LO_PROD_W - RANGE_SPLIT;
   localparam int SUM_W       = HI_PROD_W + 1;
   localparam logic [RANGE_W-1:0] NEAR_LIMIT = RANGE_W'(16777);

   // Exponent argument, Q4.16; one pipeline stage per bit
   localparam int X_W        = 20;
   localparam int NUM_STAGES = X_W;

   // Transmission accumulator, Q1.24
   localparam int TAB_W  = 24;
   localparam int FRAC_W = 24;
   localparam int ACC_W  = FRAC_W + 1;
   localparam int PROD_W = ACC_W + TAB_W;
   localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1) << FRAC_W;

   // exp(-2^(i-16)) in Q0.24, rounded to nearest
   localparam logic [TAB_W-1:0] EXP_TAB [NUM_STAGES] = '{
      24'd16776960, 24'd16776704, 24'd16776192, 24'd16775168,
      24'd16773120, 24'd16769026, 24'd16760840, 24'd16744480,
      24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
      24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
      24'd6171993,  24'd2270549,  24'd307285,   24'd5628
   };

   // Blend arithmetic, e in Q1.16
   localparam int E_W      = 17;
   localparam int E_FRAC_W = 16;
   localparam logic [E_W-1:0] E_ONE = E_W'(1) << E_FRAC_W;
   localparam int BLEND_W  = E_W + PIX_W + 1;
   localparam int SHIFT_W  = BLEND_W - E_FRAC_W;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_ATTEN_RED      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ATTEN_GREEN    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ATTEN_BLUE     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BACKDROP_RED   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_BACKDROP_GREEN = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_BACKDROP_BLUE  = 3'd5;
   localparam logic [ATTEN_W-1:0] ATTEN_RESET    = 16'd2185;
   localparam logic [PIX_W-1:0]   BACKDROP_RESET = 8'd0;

   // Channel slots: red, green, blue
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef logic [NUM_CHAN-1:0][ATTEN_W-1:0] atten_type;
   typedef logic [NUM_CHAN-1:0][PIX_W-1:0]   pix_type;

   // Classified pixel handed from front to back
   typedef struct packed {
      pix_type                       pix;
      logic [NUM_CHAN-1:0][X_W-1:0]  x;
      logic [NUM_CHAN-1:0]           kill;
   } item_type;

endpackage

// ===== hw/rtl/upa_channels.sv =====
// ----------------------------------------------------------------------------
// Underwater pixel attenuation channels
// Valid/ready interfaces for the pixel request and blended response streams.
// ----------------------------------------------------------------------------
interface upa_req_if import upa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_W-1:0]    pix_red;
   logic [PIX_W-1:0]    pix_green;
   logic [PIX_W-1:0]    pix_blue;
   logic [DEPTH_W-1:0]  depth_value;
   logic [FACTOR_W-1:0] range_factor;

   modport source (output valid, pix_red, pix_green, pix_blue, depth_value,
                   range_factor, input ready);
   modport sink (input valid, pix_red, pix_green, pix_blue, depth_value,
                 range_factor, output ready);
endinterface

interface upa_rsp_if import upa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== hw/rtl/underwater_pixel_attenuation.sv =====
// ----------------------------------------------------------------------------
// Underwater pixel attenuation top level
// A req passes the front stages, queue, exp chain and rsp register to rsp valid.
// Throughput one pixel per cycle without rsp stalls; depth set by the 20-stage exp chain.
// Synchronous reset empties all stages and the queue and loads register defaults.
// ----------------------------------------------------------------------------
`include "underwater_pixel_attenuation_macros.svh"

module underwater_pixel_attenuation import upa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   upa_req_if.sink               req_chan,
   upa_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   atten_type              atten_ff;
   pix_type                backdrop_ff;
   logic                   csr_wr;
   logic [REG_IDX_W-1:0]   csr_idx;

   logic                   q_push_valid, q_push_ready;
   logic                   q_pop_valid, q_pop_ready;
   item_type               q_push_item, q_pop_item;

   // Register file
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         atten_ff    <= {NUM_CHAN{ATTEN_RESET}};
         backdrop_ff <= {NUM_CHAN{BACKDROP_RESET}};
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ATTEN_RED:      atten_ff[CH_RED]      <= pwdata[ATTEN_W-1:0];
            REG_ATTEN_GREEN:    atten_ff[CH_GREEN]    <= pwdata[ATTEN_W-1:0];
            REG_ATTEN_BLUE:     atten_ff[CH_BLUE]     <= pwdata[ATTEN_W-1:0];
            REG_BACKDROP_RED:   backdrop_ff[CH_RED]   <= pwdata[PIX_W-1:0];
            REG_BACKDROP_GREEN: backdrop_ff[CH_GREEN] <= pwdata[PIX_W-1:0];
            REG_BACKDROP_BLUE:  backdrop_ff[CH_BLUE]  <= pwdata[PIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_idx)
         REG_ATTEN_RED:      prdata = CSR_DATA_W'(atten_ff[CH_RED]);
         REG_ATTEN_GREEN:    prdata = CSR_DATA_W'(atten_ff[CH_GREEN]);
         REG_ATTEN_BLUE:     prdata = CSR_DATA_W'(atten_ff[CH_BLUE]);
         REG_BACKDROP_RED:   prdata = CSR_DATA_W'(backdrop_ff[CH_RED]);
         REG_BACKDROP_GREEN: prdata = CSR_DATA_W'(backdrop_ff[CH_GREEN]);
         REG_BACKDROP_BLUE:  prdata = CSR_DATA_W'(backdrop_ff[CH_BLUE]);
         default:            prdata = '0;
      endcase
   end

   // Classify
   upa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .atten      (atten_ff),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item)
   );

   // Decouple
   upa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   // Exp and blend
   upa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_item  (q_pop_item),
      .backdrop  (backdrop_ff),
      .rsp_chan  (rsp_chan)
   );

   // Checks
   `UPA_ASSERT_NEXT(a_rsp_idle_after_reset, clock, 1'b0, reset, !rsp_chan.valid)
   `UPA_ASSERT_IMPL(a_no_pop_when_stalled, clock, reset, rsp_chan.valid && !rsp_chan.ready, !(q_pop_valid && q_pop_ready))
   `UPA_ASSERT_NEXT(a_unmapped_write_ignored, clock, reset, !reset && csr_wr && csr_idx > REG_BACKDROP_BLUE, $stable(atten_ff) && $stable(backdrop_ff))
   `UPA_ASSERT_NEXT(a_atten_red_written, clock, reset, !reset && csr_wr && csr_idx == REG_ATTEN_RED, atten_ff[CH_RED] == $past(pwdata[ATTEN_W-1:0]))

endmodule

// ===== hw/rtl/upa_queue.sv =====
// ----------------------------------------------------------------------------
// Underwater pixel attenuation queue
// Four-entry register queue that decouples the classifier from the exp pipe.
// ----------------------------------------------------------------------------
module upa_queue import upa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   push, pop;

   // Status and head
   assign push_ready = (cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/upa_front.sv =====
// ----------------------------------------------------------------------------
// Underwater pixel attenuation front end
// Accepts pixels, forms range and per-channel exp argument, flags underflow.
// ----------------------------------------------------------------------------
module upa_front import upa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   upa_req_if.sink   req_chan,
   input  atten_type atten,
   output logic      push_valid,
   input  logic      push_ready,
   output item_type  push_item
);

   logic                 adv;

   // Stage 1: range
   logic                 s1_valid_ff;
   pix_type              s1_pix_ff;
   logic [RANGE_W-1:0]   s1_range_ff, s1_range_in;

   // Stage 2: partial products and near flag
   logic                                s2_valid_ff;
   pix_type                             s2_pix_ff;
   logic                                s2_near_ff, s2_near_in;
   logic [NUM_CHAN-1:0][HI_PROD_W-1:0]  s2_hi_ff, s2_hi_in;
   logic [NUM_CHAN-1:0][LO_TOP_W-1:0]   s2_lotop_ff, s2_lotop_in;
   logic [LO_PROD_W-1:0]                lo_prod [NUM_CHAN];

   // Stage 3: classified item
   logic                 s3_valid_ff;
   item_type             s3_item_ff, s3_item_in;
   logic [SUM_W-1:0]     x_sum [NUM_CHAN];

   // Hold the whole front while the queue is full
   assign adv            = !s3_valid_ff || push_ready;
   assign req_chan.ready = adv;
   assign push_valid     = s3_valid_ff;
   assign push_item      = s3_item_ff;

   assign s1_range_in = RANGE_W'(req_chan.range_factor) * RANGE_W'(req_chan.depth_value);

   // Split range so each multiply stays narrow; x = hi + top of lo
   always_comb begin
      s2_near_in = (s1_range_ff <= NEAR_LIMIT);
      for (int c = 0; c < NUM_CHAN; c++) begin
         lo_prod[c]     = LO_PROD_W'(s1_range_ff[RANGE_SPLIT-1:0]) * LO_PROD_W'(atten[c]);
         s2_lotop_in[c] = lo_prod[c][LO_PROD_W-1:RANGE_SPLIT];
         s2_hi_in[c]    = HI_PROD_W'(s1_range_ff[RANGE_W-1:RANGE_SPLIT])
                          * HI_PROD_W'(atten[c]);
      end
   end

   // Classify: near range with nonzero atten, or large argument, forces zero transmission
   always_comb begin
      s3_item_in.pix = s2_pix_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         x_sum[c]           = {1'b0, s2_hi_ff[c]} + SUM_W'(s2_lotop_ff[c]);
         s3_item_in.x[c]    = x_sum[c][X_W-1:0];
         s3_item_in.kill[c] = (s2_near_ff && (atten[c] != '0))
                              || (x_sum[c][SUM_W-1:X_W] != '0);
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pix_ff   <= {req_chan.pix_blue, req_chan.pix_green, req_chan.pix_red};
         s1_range_ff <= s1_range_in;
         s2_pix_ff   <= s1_pix_ff;
         s2_near_ff  <= s2_near_in;
         s2_hi_ff    <= s2_hi_in;
         s2_lotop_ff <= s2_lotop_in;
         s3_item_ff  <= s3_item_in;
      end
   end

endmodule

// ===== hw/rtl/upa_back.sv =====
// ----------------------------------------------------------------------------
// Underwater pixel attenuation back end
// Exp pipeline, one table factor per stage, then blend into the output register.
// ----------------------------------------------------------------------------
module upa_back import upa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  item_type pop_item,
   input  pix_type  backdrop,
   upa_rsp_if.source rsp_chan
);

   logic                               adv;
   logic [NUM_STAGES:0]                st_valid_ff, st_valid_in;
   item_type                           st_item_ff [NUM_STAGES+1];
   item_type                           st_item_in [NUM_STAGES+1];
   logic [NUM_CHAN-1:0][ACC_W-1:0]     st_acc_ff [NUM_STAGES+1];
   logic [NUM_CHAN-1:0][ACC_W-1:0]     st_acc_in [NUM_STAGES+1];
   logic [PROD_W-1:0]                  prod [NUM_STAGES][NUM_CHAN];

   logic                               rsp_valid_ff;
   pix_type                            rsp_pix_ff, rsp_pix_in;
   logic [E_W-1:0]                     e_val [NUM_CHAN];
   logic [E_W-1:0]                     e_inv [NUM_CHAN];
   logic [BLEND_W-1:0]                 mix [NUM_CHAN];
   logic [SHIFT_W-1:0]                 mix_top [NUM_CHAN];

   // Stall every stage while the result waits
   assign adv       = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = adv;

   // Apply bit k of x in stage k
   always_comb begin
      st_valid_in[0] = pop_valid;
      st_item_in[0]  = pop_item;
      st_acc_in[0]   = {NUM_CHAN{ACC_ONE}};
      for (int k = 0; k < NUM_STAGES; k++) begin
         st_valid_in[k+1] = st_valid_ff[k];
         st_item_in[k+1]  = st_item_ff[k];
         for (int c = 0; c < NUM_CHAN; c++) begin
            prod[k][c] = PROD_W'(st_acc_ff[k][c]) * PROD_W'(EXP_TAB[k]);
            st_acc_in[k+1][c] = st_item_ff[k].x[c][k] ? prod[k][c][PROD_W-1:FRAC_W]
                                                       : st_acc_ff[k][c];
         end
      end
   end

   // Blend with backdrop, truncate and saturate
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         e_val[c] = st_item_ff[NUM_STAGES].kill[c] ? '0
                    : st_acc_ff[NUM_STAGES][c][ACC_W-1:ACC_W-E_W];
         e_inv[c] = E_ONE - e_val[c];
         mix[c] = BLEND_W'(e_val[c]) * BLEND_W'(st_item_ff[NUM_STAGES].pix[c])
                  + BLEND_W'(e_inv[c]) * BLEND_W'(backdrop[c]);
         mix_top[c] = mix[c][BLEND_W-1:E_FRAC_W];
         rsp_pix_in[c] = (mix_top[c][SHIFT_W-1:PIX_W] != '0) ? {PIX_W{1'b1}}
                         : mix_top[c][PIX_W-1:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         st_valid_ff  <= st_valid_in;
         rsp_valid_ff <= st_valid_ff[NUM_STAGES];
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= NUM_STAGES; k++) begin
            st_item_ff[k] <= st_item_in[k];
            st_acc_ff[k]  <= st_acc_in[k];
         end
         rsp_pix_ff <= rsp_pix_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_red   = rsp_pix_ff[CH_RED];
   assign rsp_chan.out_green = rsp_pix_ff[CH_GREEN];
   assign rsp_chan.out_blue  = rsp_pix_ff[CH_BLUE];

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Underwater pixel attenuation testbench
// Runs a short table of fixed pixels, then random pixels under eight register
// settings and four idling patterns. A scoreboard predicts each blended color
// at pixel acceptance and compares it field by field with the response.
// ----------------------------------------------------------------------------
module tb_top;
   import upa_pkg::*;

   localparam int          NUM_SETTINGS    = 8;
   localparam int          PIXELS_PER_SET  = 200;
   localparam int          QUIET_LIMIT     = 4000;
   localparam int          DRAIN_CYCLES    = 40;
   localparam int          MAX_REPORTS     = 10;
   localparam int          NUM_EXP_STEPS   = 20;
   localparam logic [39:0] NEAR_RANGE_Q24  = 40'd16777;
   localparam logic [63:0] UNDERFLOW_X_Q16 = 64'd1 << 20;
   localparam logic [16:0] UNITY_Q16       = 17'd65536;

   // Addresses beyond the register map; writes there must be dropped
   localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [23:0] depth;
      logic [15:0] factor;
   } pixel_t;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_t;

   typedef struct {
      pixel_t px;
      bit     typed;
      color_t colors;
   } pixel_row_t;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   upa_req_if req_if ();
   upa_rsp_if rsp_if ();

   underwater_pixel_attenuation dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // exp(-2^(i-16)) in Q0.24, one factor per bit of the exponent
   logic [23:0] exp_steps [NUM_EXP_STEPS] = '{
      24'd16776960, 24'd16776704, 24'd16776192, 24'd16775168,
      24'd16773120, 24'd16769026, 24'd16760840, 24'd16744480,
      24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
      24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
      24'd6171993,  24'd2270549,  24'd307285,   24'd5628
   };

   logic [REG_IDX_W-1:0] reg_order [6] = '{
      REG_ATTEN_RED, REG_ATTEN_GREEN, REG_ATTEN_BLUE,
      REG_BACKDROP_RED, REG_BACKDROP_GREEN, REG_BACKDROP_BLUE
   };

   // Register shadow, indexed by register number, holding the masked value
   logic [31:0] shadow_regs [8] = '{
      32'd2185, 32'd2185, 32'd2185, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
   };

   // Near range, deep underflow, factor below one and plain cases at reset setting
   pixel_row_t directed_rows [16] = '{
      '{'{8'hff, 8'hff, 8'hff, 24'd0,        16'hffff}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{8'hff, 8'hff, 8'hff, 24'hffffff,   16'hffff}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{8'hab, 8'hcd, 8'hef, 24'd1,        16'd16777}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{8'hab, 8'hcd, 8'hef, 24'd1,        16'd16778}, 1'b1, '{8'haa, 8'hcc, 8'hee}},
      '{'{8'hff, 8'h80, 8'h01, 24'hffffff,   16'd0},     1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{8'hff, 8'hff, 8'hff, 24'd1,        16'd16384}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{8'hff, 8'hff, 8'hff, 24'd491416,   16'd16384}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{8'h12, 8'h34, 8'h56, 24'd1,        16'hffff}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{8'hff, 8'hff, 8'hff, 24'd16384,    16'd16384}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{8'hff, 8'hff, 8'hff, 24'd491415,   16'd16384}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{8'h00, 8'h00, 8'h00, 24'd1024,     16'd16384}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{8'h55, 8'haa, 8'h55, 24'haaaaaa,   16'h5555}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{8'haa, 8'h55, 8'haa, 24'h000555,   16'haaaa}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{8'h80, 8'h80, 8'h80, 24'd100000,   16'd40000}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{8'hff, 8'h00, 8'hff, 24'd2048,     16'hffff}, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{'{8'h01, 8'hfe, 8'h7f, 24'h00ffff,   16'd16384}, 1'b0, '{8'd0, 8'd0, 8'd0}}
   };

   color_t pending_colors [$];
   int     mismatch_count;
   int     quiet_cycles;
   int     send_idle_pct;
   int     recv_stall_pct;

   // Transmission e = exp(-range * atten) in Q1.16
   function automatic logic [16:0] transmission(logic [39:0] range_q24, bit near,
                                                logic [15:0] atten);
      logic [63:0] x_q16;
      logic [63:0] acc;
      if (near) begin
         return (atten == 16'd0) ? UNITY_Q16 : 17'd0;
      end
      x_q16 = (64'(range_q24) * 64'(atten)) >> 24;
      if (x_q16 >= UNDERFLOW_X_Q16) begin
         return 17'd0;
      end
      acc = 64'd1 << 24;
      for (int i = 0; i < NUM_EXP_STEPS; i++) begin
         if (x_q16[i]) begin
            acc = (acc * 64'(exp_steps[i])) >> 24;
         end
      end
      return acc[24:8];
   endfunction

   // Blend each channel toward the backdrop by its transmission
   function automatic color_t attenuate_pixel(pixel_t px);
      logic [39:0] range_q24;
      bit          near;
      logic [7:0]  pix [3];
      logic [7:0]  shade [3];
      logic [16:0] e16;
      logic [31:0] mix;
      range_q24 = 40'(px.factor) * 40'(px.depth);
      near      = (range_q24 <= NEAR_RANGE_Q24);
      pix[0]    = px.red;
      pix[1]    = px.green;
      pix[2]    = px.blue;
      for (int ch = 0; ch < 3; ch++) begin
         e16 = transmission(range_q24, near, shadow_regs[REG_ATTEN_RED + ch][15:0]);
         mix = (32'(e16) * 32'(pix[ch]) +
                32'(UNITY_Q16 - e16) * 32'(shadow_regs[REG_BACKDROP_RED + ch][7:0])) >> 16;
         shade[ch] = (mix > 32'd255) ? 8'd255 : mix[7:0];
      end
      return '{shade[0], shade[1], shade[2]};
   endfunction

   function automatic void note_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
      end
   endfunction

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ATTEN_RED, REG_ATTEN_GREEN, REG_ATTEN_BLUE: begin
            shadow_regs[idx] = {16'd0, data[15:0]};
         end
         REG_BACKDROP_RED, REG_BACKDROP_GREEN, REG_BACKDROP_BLUE: begin
            shadow_regs[idx] = {24'd0, data[7:0]};
         end
         default: begin
            // spare addresses hold nothing
         end
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [REG_IDX_W-1:0] idx, output logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data    = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the pixel until its transaction completes, then queue its prediction
   task automatic send_pixel(input pixel_t px, input bit typed, input color_t typed_colors);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.pix_red      <= px.red;
      req_if.pix_green    <= px.green;
      req_if.pix_blue     <= px.blue;
      req_if.depth_value  <= px.depth;
      req_if.range_factor <= px.factor;
      do @(posedge clock); while (!req_if.ready);
      pending_colors.push_back(typed ? typed_colors : attenuate_pixel(px));
   endtask

   task automatic drain_pixels();
      req_if.valid <= 1'b0;
      while (pending_colors.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stall the response side at the current rate
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      color_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_colors.size() == 0) begin
            note_mismatch("unexpected response, red", -1, rsp_if.out_red);
         end else begin
            want = pending_colors.pop_front();
            if (rsp_if.out_red !== want.red) begin
               note_mismatch("out_red", want.red, rsp_if.out_red);
            end
            if (rsp_if.out_green !== want.green) begin
               note_mismatch("out_green", want.green, rsp_if.out_green);
            end
            if (rsp_if.out_blue !== want.blue) begin
               note_mismatch("out_blue", want.blue, rsp_if.out_blue);
            end
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || psel || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      pixel_t      px;
      logic [31:0] vals [6];
      logic [31:0] readback;
      logic [15:0] atten;
      logic [7:0]  backdrop;
      int          shape;
      int          span;
      int          phase;

      mismatch_count      = 0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_if.valid        <= 1'b0;
      req_if.pix_red      <= '0;
      req_if.pix_green    <= '0;
      req_if.pix_blue     <= '0;
      req_if.depth_value  <= '0;
      req_if.range_factor <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Fixed pixels at the reset setting
      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].colors);
      end

      for (int k = 0; k < NUM_SETTINGS; k++) begin
         drain_pixels();

         // Pick the setting; extremes first, then random spreads
         for (int c = 0; c < 3; c++) begin
            case (k)
               1: begin
                  atten    = 16'd0;
                  backdrop = 8'd255;
               end
               2: begin
                  atten    = 16'hffff;
                  backdrop = 8'd0;
               end
               3: begin
                  atten    = 16'($urandom_range(0, 2047));
                  backdrop = 8'($urandom);
               end
               4: begin
                  atten    = (c == 0) ? 16'd0 : (c == 1) ? 16'hffff : 16'($urandom);
                  backdrop = (c == 0) ? 8'd255 : (c == 1) ? 8'd0 : 8'($urandom);
               end
               5: begin
                  atten    = 16'($urandom);
                  backdrop = 8'($urandom);
               end
               6: begin
                  atten    = 16'($urandom_range(0, 255));
                  backdrop = 8'($urandom);
               end
               default: begin
                  atten    = 16'($urandom_range(0, 8191));
                  backdrop = 8'($urandom);
               end
            endcase
            vals[c]     = {16'($urandom), atten};
            vals[c + 3] = {24'($urandom), backdrop};
         end

         // Program the setting while the pipe is empty; the first pass keeps reset values
         if (k != 0) begin
            foreach (reg_order[r]) begin
               csr_write(reg_order[r], vals[r]);
            end
         end
         if (k == 4) begin
            csr_write(REG_SPARE_A, $urandom);
            csr_write(REG_SPARE_B, $urandom);
         end
         foreach (reg_order[r]) begin
            csr_read(reg_order[r], readback);
            if (readback !== shadow_regs[reg_order[r]]) begin
               note_mismatch("register readback", shadow_regs[reg_order[r]], readback);
            end
         end

         phase          = k % 4;
         send_idle_pct  = (phase == 1) ? 56 : (phase == 3) ? 28 : 0;
         recv_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 28 : 0;

         for (int j = 0; j < PIXELS_PER_SET; j++) begin
            // Hold off mid-run until every response is back
            if (k == 5 && j == PIXELS_PER_SET / 2) begin
               drain_pixels();
            end
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
            shape    = $urandom_range(99);
            if (shape < 8) begin
               // straddle the near-range threshold
               px.depth  = 24'($urandom_range(0, 1));
               px.factor = 16'($urandom_range(16300, 17100));
            end else begin
               // spread depth over magnitudes so short ranges are common
               span      = $urandom_range(1, 24);
               px.depth  = 24'($urandom) & 24'((32'd1 << span) - 1);
               px.factor = (shape < 80) ? 16'($urandom_range(16384, 65535)) : 16'($urandom);
            end
            send_pixel(px, 1'b0, '0);
         end
      end

      drain_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_colors.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
